[rtl/assert_macros.svh]
// Assertion macros shared by the RTL files.
// Depends on signals named clk and rst_n in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");
`define ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, cond)
`define ASSERT_IMPLY(label, ante, cons)
`endif
`endif

[rtl/cisp_pkg.sv]
// Types and constants for the cartridge image stream parser.
// No dependencies.
`timescale 1ns / 1ps

package cisp_pkg;

  localparam int HEADER_BYTES = 16;
  localparam int CNT_W        = 22;
  localparam int PRG_SHIFT    = 14;  // 16 KiB units
  localparam int CHR_SHIFT    = 13;  // 8 KiB units

  // magic bytes 0..3, index 0 in the low byte
  localparam logic [3:0][7:0] MAGIC = {8'h1A, 8'h53, 8'h45, 8'h4E};

  typedef enum logic [2:0] {
    KIND_HEADER = 3'd0,
    KIND_ACCEPT = 3'd1,
    KIND_PRG    = 3'd2,
    KIND_CHR    = 3'd3,
    KIND_IGNORE = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE   = 3'd0,
    ERR_MAGIC  = 3'd1,
    ERR_VS     = 3'd2,
    ERR_PC     = 3'd3,
    ERR_NES20  = 3'd4
  } err_t;

  typedef enum logic [3:0] {
    PH_IGNORE = 4'b0001,
    PH_HEADER = 4'b0010,
    PH_PRG    = 4'b0100,
    PH_CHR    = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       start_req;
  } in_item_t;

  typedef struct packed {
    kind_t              kind;
    logic [CNT_W-1:0]   offset;
    logic [7:0]         data;
    logic [7:0]         prg_units;
    logic [7:0]         chr_units;
    logic [7:0]         mapper_number;
    logic               mirroring;
    logic               battery;
    logic               trainer_present;
    logic               four_screen;
    err_t               error_code;
    logic               image_end;
  } out_item_t;

endpackage

[rtl/cartridge_image_stream_parser.sv]
// Cartridge image stream parser: header capture and check, region tagging.
// Depends on cisp_pkg and assert_macros.svh.
// An item passes the input register, then the result register, on its way to out_valid.
// Throughput: one item per cycle; the parse state updates as an item moves to the result.
// in_stall rises only when both registers hold items and out_stall is high.
// Reset (rst_n low, synchronous): both registers empty, parser ignoring until a start.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cartridge_image_stream_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  cisp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output cisp_pkg::out_item_t out_data
);

  localparam int CW = cisp_pkg::CNT_W;

  logic                in_valid_r;
  cisp_pkg::in_item_t  in_r;
  logic                out_valid_r;
  cisp_pkg::out_item_t out_r;

  cisp_pkg::phase_t    phase_r, phase_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic                magic_ok_r, magic_ok_nxt;
  logic [7:0]          prg_r, prg_nxt;
  logic [7:0]          chr_r, chr_nxt;
  logic [7:0]          f6_r, f6_nxt;
  logic [7:0]          f7_r, f7_nxt;
  cisp_pkg::err_t      err_r, err_nxt;
  cisp_pkg::out_item_t res;

  logic adv_out, adv_in, step;

  assign adv_out  = !out_valid_r || !out_stall;
  assign adv_in   = !in_valid_r || adv_out;
  assign step     = in_valid_r && adv_out;
  assign in_stall = !adv_in;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    logic [CW:0]   cnt_inc;
    logic [CW-1:0] plen;
    logic [CW-1:0] clen;
    logic          magic_hit;
    cisp_pkg::phase_t ph;

    ph           = phase_r;
    cnt_nxt      = cnt_r;
    magic_ok_nxt = magic_ok_r;
    prg_nxt      = prg_r;
    chr_nxt      = chr_r;
    f6_nxt       = f6_r;
    f7_nxt       = f7_r;
    err_nxt      = err_r;
    res          = '0;
    res.kind     = cisp_pkg::KIND_IGNORE;
    res.offset   = '0;
    res.image_end = 1'b0;

    // restart on start flag: clear latched fields
    if (in_r.start_req) begin
      ph           = cisp_pkg::PH_HEADER;
      cnt_nxt      = '0;
      magic_ok_nxt = 1'b0;
      prg_nxt      = '0;
      chr_nxt      = '0;
      f6_nxt       = '0;
      f7_nxt       = '0;
      err_nxt      = cisp_pkg::ERR_NONE;
    end

    cnt_inc   = {1'b0, cnt_nxt} + {{CW{1'b0}}, 1'b1};
    plen      = {prg_nxt, {cisp_pkg::PRG_SHIFT{1'b0}}};
    clen      = {{(CW - 8 - cisp_pkg::CHR_SHIFT){1'b0}}, chr_nxt,
                 {cisp_pkg::CHR_SHIFT{1'b0}}};
    magic_hit = (in_r.byte_in == cisp_pkg::MAGIC[cnt_nxt[1:0]]);
    phase_nxt = ph;

    case (ph)
      cisp_pkg::PH_HEADER: begin
        res.kind   = cisp_pkg::KIND_HEADER;
        res.offset = cnt_nxt;
        if (cnt_nxt < CW'(4)) begin
          magic_ok_nxt = (cnt_nxt == '0) ? magic_hit : (magic_ok_nxt && magic_hit);
        end else if (cnt_nxt == CW'(4)) begin
          prg_nxt = in_r.byte_in;
        end else if (cnt_nxt == CW'(5)) begin
          chr_nxt = in_r.byte_in;
        end else if (cnt_nxt == CW'(6)) begin
          f6_nxt = in_r.byte_in;
        end else if (cnt_nxt == CW'(7)) begin
          f7_nxt = in_r.byte_in;
        end
        if (cnt_nxt >= CW'(cisp_pkg::HEADER_BYTES - 1)) begin
          // last header byte: run the checks in priority order
          if (!magic_ok_nxt)              err_nxt = cisp_pkg::ERR_MAGIC;
          else if (f7_nxt[0])             err_nxt = cisp_pkg::ERR_VS;
          else if (f7_nxt[1])             err_nxt = cisp_pkg::ERR_PC;
          else if (f7_nxt[3:2] != 2'b00)  err_nxt = cisp_pkg::ERR_NES20;
          else                            err_nxt = cisp_pkg::ERR_NONE;
          cnt_nxt = '0;
          if (err_nxt != cisp_pkg::ERR_NONE) begin
            phase_nxt = cisp_pkg::PH_IGNORE;
          end else begin
            res.kind = cisp_pkg::KIND_ACCEPT;
            if (prg_nxt != '0) begin
              phase_nxt = cisp_pkg::PH_PRG;
            end else if (chr_nxt != '0) begin
              phase_nxt = cisp_pkg::PH_CHR;
            end else begin
              phase_nxt     = cisp_pkg::PH_IGNORE;
              res.image_end = 1'b1;
            end
          end
        end else begin
          cnt_nxt = cnt_inc[CW-1:0];
        end
      end
      cisp_pkg::PH_PRG: begin
        res.kind   = cisp_pkg::KIND_PRG;
        res.offset = cnt_nxt;
        if (cnt_inc >= {1'b0, plen}) begin
          cnt_nxt = '0;
          if (chr_nxt != '0) begin
            phase_nxt = cisp_pkg::PH_CHR;
          end else begin
            phase_nxt     = cisp_pkg::PH_IGNORE;
            res.image_end = 1'b1;
          end
        end else begin
          cnt_nxt = cnt_inc[CW-1:0];
        end
      end
      cisp_pkg::PH_CHR: begin
        res.kind   = cisp_pkg::KIND_CHR;
        res.offset = cnt_nxt;
        if (cnt_inc >= {1'b0, clen}) begin
          cnt_nxt       = '0;
          phase_nxt     = cisp_pkg::PH_IGNORE;
          res.image_end = 1'b1;
        end else begin
          cnt_nxt = cnt_inc[CW-1:0];
        end
      end
      default: begin
        phase_nxt = cisp_pkg::PH_IGNORE;
      end
    endcase

    res.data            = in_r.byte_in;
    res.prg_units       = prg_nxt;
    res.chr_units       = chr_nxt;
    res.mapper_number   = {f7_nxt[7:4], f6_nxt[7:4]};
    res.mirroring       = f6_nxt[0];
    res.battery         = f6_nxt[1];
    res.trainer_present = f6_nxt[2];
    res.four_screen     = f6_nxt[3];
    res.error_code      = err_nxt;
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (adv_in) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_in && in_valid) begin
      in_r <= in_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv_out) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_r <= res;
    end
  end

  // parse state advances when an item moves into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= cisp_pkg::PH_IGNORE;
      cnt_r      <= '0;
      magic_ok_r <= 1'b0;
      prg_r      <= '0;
      chr_r      <= '0;
      f6_r       <= '0;
      f7_r       <= '0;
      err_r      <= cisp_pkg::ERR_NONE;
    end else if (step) begin
      phase_r    <= phase_nxt;
      cnt_r      <= cnt_nxt;
      magic_ok_r <= magic_ok_nxt;
      prg_r      <= prg_nxt;
      chr_r      <= chr_nxt;
      f6_r       <= f6_nxt;
      f7_r       <= f7_nxt;
      err_r      <= err_nxt;
    end
  end

  `ASSERT_IMPLY(a_accept_no_err, out_valid_r && out_r.kind == cisp_pkg::KIND_ACCEPT, out_r.error_code == cisp_pkg::ERR_NONE)
  `ASSERT_IMPLY(a_end_kind, out_valid_r && out_r.image_end, out_r.kind == cisp_pkg::KIND_ACCEPT || out_r.kind == cisp_pkg::KIND_PRG || out_r.kind == cisp_pkg::KIND_CHR)
  `ASSERT_IMPLY(a_idle_cnt, phase_r == cisp_pkg::PH_IGNORE, cnt_r == '0)
  `ASSERT_IMPLY(a_err_ignores, err_r != cisp_pkg::ERR_NONE, phase_r == cisp_pkg::PH_IGNORE)
  `ASSERT_ALWAYS(a_stall_only_full, !in_stall || (in_valid_r && out_valid_r))

endmodule

[tb/sv/cartridge_image_stream_parser_tb.sv]
// Self-checking bench for cartridge_image_stream_parser: directed header cases, then random
// headers with short bodies and loose random bytes. Randomized idling on both sides.
// Depends on cisp_pkg and the parser RTL only.
`timescale 1ns / 1ps

module cartridge_image_stream_parser_tb;

  typedef logic [cisp_pkg::HEADER_BYTES-1:0][7:0] header_bytes_t;

  localparam logic [3:0][7:0] ID_SIG = {8'h1A, 8'h53, 8'h45, 8'h4E};
  localparam int ITEM_TARGET = 650;
  localparam int LONG_HOLD   = 64;
  localparam int DRAIN       = 8;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  cisp_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_stall;
  cisp_pkg::out_item_t out_data;

  bit          tx_quiet;
  bit          rx_quiet;
  int          holds_wanted;
  int          holds_served;

  cartridge_image_stream_parser u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // Tracks the parse state of the image stream and holds the results still due.
  class image_tracker;
    cisp_pkg::phase_t          stage;
    logic [cisp_pkg::CNT_W-1:0] count;
    bit                        magic_good;
    logic [7:0]                prg;
    logic [7:0]                chr;
    logic [7:0]                f6;
    logic [7:0]                f7;
    cisp_pkg::err_t            verdict;
    cisp_pkg::out_item_t       due_results[$];
    int unsigned               faults;
    int unsigned               taken;
    int unsigned               live;
    int unsigned               checked;
    int unsigned               accepts;
    int unsigned               ends;
    int unsigned               rejects[5];

    function new();
      stage = cisp_pkg::PH_IGNORE;
      count = '0;
      magic_good = 1'b0;
      prg = '0;
      chr = '0;
      f6 = '0;
      f7 = '0;
      verdict = cisp_pkg::ERR_NONE;
    endfunction

    function void take_byte(cisp_pkg::in_item_t it);
      cisp_pkg::out_item_t r;
      logic [7:0]          b;
      bit                  sig_ok;
      int unsigned         span;
      b = it.byte_in;
      r = '0;
      r.kind = cisp_pkg::KIND_IGNORE;
      if (it.start_req) begin
        count = '0;
        magic_good = 1'b0;
        prg = '0;
        chr = '0;
        f6 = '0;
        f7 = '0;
        verdict = cisp_pkg::ERR_NONE;
        stage = cisp_pkg::PH_HEADER;
      end
      case (stage)
        cisp_pkg::PH_HEADER: begin
          r.kind = cisp_pkg::KIND_HEADER;
          r.offset = count;
          if (count < 4) begin
            sig_ok = (b == ID_SIG[count[1:0]]);
            magic_good = (count == 0) ? sig_ok : (magic_good & sig_ok);
          end else if (count == 4) begin
            prg = b;
          end else if (count == 5) begin
            chr = b;
          end else if (count == 6) begin
            f6 = b;
          end else if (count == 7) begin
            f7 = b;
          end
          if (count >= cisp_pkg::HEADER_BYTES - 1) begin
            count = '0;
            // first failing check wins
            if (!magic_good) verdict = cisp_pkg::ERR_MAGIC;
            else if (f7[0]) verdict = cisp_pkg::ERR_VS;
            else if (f7[1]) verdict = cisp_pkg::ERR_PC;
            else if (f7[3:2] != 2'b00) verdict = cisp_pkg::ERR_NES20;
            else verdict = cisp_pkg::ERR_NONE;
            if (verdict != cisp_pkg::ERR_NONE) begin
              stage = cisp_pkg::PH_IGNORE;
              rejects[verdict]++;
            end else begin
              r.kind = cisp_pkg::KIND_ACCEPT;
              accepts++;
              if (prg != 0) begin
                stage = cisp_pkg::PH_PRG;
              end else if (chr != 0) begin
                stage = cisp_pkg::PH_CHR;
              end else begin
                stage = cisp_pkg::PH_IGNORE;
                r.image_end = 1'b1;
              end
            end
          end else begin
            count = count + 1'b1;
          end
        end
        cisp_pkg::PH_PRG, cisp_pkg::PH_CHR: begin
          span = (stage == cisp_pkg::PH_PRG) ? (int'(prg) << cisp_pkg::PRG_SHIFT)
                                             : (int'(chr) << cisp_pkg::CHR_SHIFT);
          r.kind = (stage == cisp_pkg::PH_PRG) ? cisp_pkg::KIND_PRG : cisp_pkg::KIND_CHR;
          r.offset = count;
          if (int'(count) + 1 >= span) begin
            count = '0;
            if (stage == cisp_pkg::PH_PRG && chr != 0) begin
              stage = cisp_pkg::PH_CHR;
            end else begin
              stage = cisp_pkg::PH_IGNORE;
              r.image_end = 1'b1;
            end
          end else begin
            count = count + 1'b1;
          end
        end
        default: stage = cisp_pkg::PH_IGNORE;
      endcase
      r.data = b;
      r.prg_units = prg;
      r.chr_units = chr;
      r.mapper_number = {f7[7:4], f6[7:4]};
      r.mirroring = f6[0];
      r.battery = f6[1];
      r.trainer_present = f6[2];
      r.four_screen = f6[3];
      r.error_code = verdict;
      taken++;
      if (r.kind != cisp_pkg::KIND_IGNORE) live++;
      if (r.image_end) ends++;
      due_results.push_back(r);
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        faults++;
        $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
      end
    endfunction

    function void match_result(cisp_pkg::out_item_t got);
      cisp_pkg::out_item_t want;
      if (due_results.size() == 0) begin
        faults++;
        $display("%0t: result with nothing expected: expected none, got %h", $time, got);
        return;
      end
      want = due_results.pop_front();
      checked++;
      check_field("kind",            want.kind,            got.kind);
      check_field("offset",          want.offset,          got.offset);
      check_field("data",            want.data,            got.data);
      check_field("prg_units",       want.prg_units,       got.prg_units);
      check_field("chr_units",       want.chr_units,       got.chr_units);
      check_field("mapper_number",   want.mapper_number,   got.mapper_number);
      check_field("mirroring",       want.mirroring,       got.mirroring);
      check_field("battery",         want.battery,         got.battery);
      check_field("trainer_present", want.trainer_present, got.trainer_present);
      check_field("four_screen",     want.four_screen,     got.four_screen);
      check_field("error_code",      want.error_code,      got.error_code);
      check_field("image_end",       want.image_end,       got.image_end);
    endfunction
  endclass

  image_tracker tracker = new();

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #100_000_000;
    $display("cartridge_image_stream_parser_tb: done, errors");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) tracker.take_byte(in_data);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tracker.match_result(out_data);
  end

  // Result side: random stall runs, quiet stretches, and long holds on request.
  initial begin : receiver
    int run;
    int r;
    forever begin
      if (holds_served != holds_wanted) begin
        holds_served++;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (rx_quiet) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          out_stall <= 1'b0;
          run = $urandom_range(1, 4);
        end else if (r < 92) begin
          out_stall <= 1'b1;
          run = $urandom_range(1, 3);
        end else begin
          out_stall <= 1'b1;
          run = $urandom_range(8, 30);
        end
        repeat (run) @(posedge clk);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (tx_quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 24);
  endfunction

  // Offer one item and return right after the edge that takes it.
  task automatic send_byte(input logic [7:0] b, input bit s);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{byte_in: b, start_req: s};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic header_bytes_t make_header(logic [7:0] prg, logic [7:0] chr,
                                                logic [7:0] f6, logic [7:0] f7);
    header_bytes_t h;
    for (int i = 0; i < cisp_pkg::HEADER_BYTES; i++) h[i] = 8'($urandom);
    for (int i = 0; i < 4; i++) h[i] = ID_SIG[i];
    h[4] = prg;
    h[5] = chr;
    h[6] = f6;
    h[7] = f7;
    return h;
  endfunction

  task automatic send_header(input header_bytes_t h, input int cut);
    for (int i = 0; i < cut; i++) send_byte(h[i], i == 0);
  endtask

  function automatic logic [7:0] pick_units();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return 8'($urandom_range(0, 2));
    if (sel < 8) return 8'hFF;
    return 8'($urandom);
  endfunction

  // Header with random content and a short body; sometimes broken or cut off.
  task automatic random_image();
    header_bytes_t h;
    logic [7:0]    f7;
    int            sel;
    int            idx;
    int            cut;
    int            body;
    sel = $urandom_range(0, 9);
    if (sel < 5) f7 = {4'($urandom), 4'b0000};
    else if (sel == 5) f7 = {4'($urandom), 3'($urandom), 1'b1};
    else if (sel == 6) f7 = {4'($urandom), 2'($urandom), 2'b10};
    else if (sel == 7) f7 = {4'($urandom), 2'($urandom_range(1, 3)), 2'b00};
    else f7 = 8'($urandom);
    h = make_header(pick_units(), pick_units(), 8'($urandom), f7);
    if ($urandom_range(0, 9) == 0) begin
      idx = $urandom_range(0, 3);
      h[idx] = h[idx] ^ 8'($urandom_range(1, 255));
    end
    cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, cisp_pkg::HEADER_BYTES - 1)
                                      : cisp_pkg::HEADER_BYTES;
    send_header(h, cut);
    if (cut == cisp_pkg::HEADER_BYTES) begin
      body = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 48) : $urandom_range(0, 6);
      repeat (body) send_byte(8'($urandom), 1'b0);
    end
  endtask

  initial begin : stimulus
    header_bytes_t h;
    int            round;
    bit            quiet;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    holds_wanted = 0;
    holds_served = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // bytes before any start are ignored
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    // start, then restart in the middle of the header
    send_header(make_header(8'hFF, 8'hFF, 8'h00, 8'h00), 5);
    // empty image: ends on its last header byte, all flag bits set
    h = make_header(8'h00, 8'h00, 8'hFF, 8'hF0);
    for (int i = 8; i < cisp_pkg::HEADER_BYTES; i++) h[i] = 8'hFF;
    send_header(h, cisp_pkg::HEADER_BYTES);
    send_byte(8'h00, 1'b0);

    round = 0;
    while (tracker.taken < ITEM_TARGET) begin
      round++;
      if (round % 40 == 5) begin
        // back up the result side and keep offering so the input stalls
        tx_quiet = 1'b1;
        rx_quiet = 1'b0;
        holds_wanted++;
      end else begin
        quiet = ($urandom_range(0, 4) == 0);
        tx_quiet = quiet;
        rx_quiet = quiet;
      end
      if ($urandom_range(0, 9) < 7) random_image();
      else repeat ($urandom_range(1, 4)) send_byte(8'($urandom), $urandom_range(0, 3) == 0);
    end

    in_valid <= 1'b0;
    rx_quiet = 1'b1;
    // let the last accepted item reach the tracker before watching the queue
    @(posedge clk);
    while (tracker.due_results.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("covered %0d bytes (%0d tagged, %0d results checked), %0d headers accepted",
             tracker.taken, tracker.live, tracker.checked, tracker.accepts);
    $display("%0d images ended; headers rejected: magic %0d, vs %0d, playchoice %0d, v2 %0d",
             tracker.ends, tracker.rejects[cisp_pkg::ERR_MAGIC],
             tracker.rejects[cisp_pkg::ERR_VS], tracker.rejects[cisp_pkg::ERR_PC],
             tracker.rejects[cisp_pkg::ERR_NES20]);
    if (tracker.faults == 0 && tracker.due_results.size() == 0) begin
      $display("cartridge_image_stream_parser_tb: done, clean");
    end else begin
      $display("cartridge_image_stream_parser_tb: done, errors");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/cisp_pkg.sv
rtl/cartridge_image_stream_parser.sv
tb/sv/cartridge_image_stream_parser_tb.sv
